// ===== design/bdc_pkg.sv =====
package bdc_pkg;

   // Default width of the internal time base; timestamps wrap at this width.
   localparam int TIME_WIDTH_DEFAULT = 32;

   localparam int STAMP_WIDTH     = 32;
   localparam int CFG_WIDTH       = 16;
   localparam int CSR_INDEX_WIDTH = 8;

   // Register map of the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE_TIME   = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CLICK_WINDOW    = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS_TIME = 8'd2;

   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_TIME_RESET   = 16'd20;
   localparam logic [CFG_WIDTH-1:0] CLICK_WINDOW_RESET    = 16'd400;
   localparam logic [CFG_WIDTH-1:0] LONG_PRESS_TIME_RESET = 16'd700;

   localparam logic [1:0] TALLY_MAX = 2'd3;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_PRESSED = 2'd1,
      PH_MULTI   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_PRESS   = 2'd1,
      EV_RELEASE = 2'd2
   } event_type;

   typedef enum logic [2:0] {
      GESTURE_NONE   = 3'd0,
      GESTURE_SINGLE = 3'd1,
      GESTURE_DOUBLE = 3'd2,
      GESTURE_TRIPLE = 3'd3,
      GESTURE_LONG   = 3'd4
   } action_type;

   typedef struct packed {
      logic [STAMP_WIDTH-1:0] timestamp;
      logic                   edge_seen;
      logic                   pin_level;
   } req_type;

   typedef struct packed {
      logic [2:0] action;
      logic [1:0] debounced_event;
      logic       pressed_level;
   } rsp_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] debounce_time;
      logic [CFG_WIDTH-1:0] click_window;
      logic [CFG_WIDTH-1:0] long_press_time;
   } cfg_type;

   // What the debouncer produces in one step: the event for the classifier and the debounced level.
   typedef struct packed {
      event_type ev;
      logic      pressed_level;
   } deb_result_type;

endpackage

// ===== design/bdc_debounce.sv =====
module bdc_debounce #(
   parameter int TIME_WIDTH = bdc_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic [TIME_WIDTH-1:0]           now,
   input  logic                            edge_seen,
   input  logic                            pressed,
   input  logic [bdc_pkg::CFG_WIDTH-1:0]   debounce_time,
   output bdc_pkg::deb_result_type         result
);

   logic                  stable_ff,    stable_in;
   logic                  candidate_ff, candidate_in;
   logic                  active_ff,    active_in;
   logic [TIME_WIDTH-1:0] due_ff,       due_in;

   logic [TIME_WIDTH-1:0] dt_ext;
   logic [TIME_WIDTH-1:0] diff;
   logic                  active;
   logic                  reached;
   logic                  fire;
   logic                  change;

   always_comb begin
      dt_ext       = TIME_WIDTH'(debounce_time);
      candidate_in = edge_seen ? pressed : candidate_ff;
      due_in       = edge_seen ? (now + dt_ext) : due_ff;
      active       = edge_seen | active_ff;
      // A fresh deadline gives now - due = -debounce_time, so that difference
      // is formed in parallel with the sum rather than after it.
      diff         = edge_seen ? (TIME_WIDTH'(0) - dt_ext) : (now - due_ff);
      reached      = ~diff[TIME_WIDTH-1];
      fire         = active & reached;
      active_in    = active & ~reached;
      change       = fire & (pressed == candidate_in) & (pressed != stable_ff);
      stable_in    = change ? pressed : stable_ff;

      result.pressed_level = stable_in;
      if (!change) begin
         result.ev = bdc_pkg::EV_NONE;
      end else if (pressed) begin
         result.ev = bdc_pkg::EV_PRESS;
      end else begin
         result.ev = bdc_pkg::EV_RELEASE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff    <= 1'b0;
         candidate_ff <= 1'b0;
         active_ff    <= 1'b0;
         due_ff       <= '0;
      end else if (step) begin
         stable_ff    <= stable_in;
         candidate_ff <= candidate_in;
         active_ff    <= active_in;
         due_ff       <= due_in;
      end
   end

endmodule

// ===== design/bdc_classify.sv =====
module bdc_classify #(
   parameter int TIME_WIDTH = bdc_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic [TIME_WIDTH-1:0]           now,
   input  bdc_pkg::event_type              ev,
   input  logic [bdc_pkg::CFG_WIDTH-1:0]   click_window,
   input  logic [bdc_pkg::CFG_WIDTH-1:0]   long_press_time,
   output bdc_pkg::action_type             action
);

   bdc_pkg::phase_type    phase_ff, phase_in;
   logic [TIME_WIDTH-1:0] press_start_ff, press_start_in;
   logic [TIME_WIDTH-1:0] window_due_ff, window_due_in;
   logic [1:0]            tally_ff, tally_in;
   logic                  long_done_ff, long_done_in;

   logic [TIME_WIDTH-1:0] cw_ext;
   logic [TIME_WIDTH-1:0] hold_old;
   logic [TIME_WIDTH-1:0] hold;
   logic [TIME_WIDTH-1:0] win_diff_old;
   logic [TIME_WIDTH-1:0] win_diff_new;
   logic [TIME_WIDTH-1:0] win_diff;
   logic [1:0]            tally_inc;
   logic                  press_new;
   logic                  window_new;

   always_comb begin
      cw_ext        = TIME_WIDTH'(click_window);
      hold_old      = now - press_start_ff;
      win_diff_old  = now - window_due_ff;
      win_diff_new  = TIME_WIDTH'(0) - cw_ext;
      tally_inc     = (tally_ff == bdc_pkg::TALLY_MAX) ? tally_ff : tally_ff + 2'd1;

      phase_in       = phase_ff;
      press_start_in = press_start_ff;
      window_due_in  = window_due_ff;
      tally_in       = tally_ff;
      long_done_in   = long_done_ff;
      press_new      = 1'b0;
      window_new     = 1'b0;
      action         = bdc_pkg::GESTURE_NONE;

      case (phase_ff)
         bdc_pkg::PH_PRESSED: begin
            if (ev == bdc_pkg::EV_RELEASE) begin
               phase_in      = bdc_pkg::PH_MULTI;
               tally_in      = tally_inc;
               window_due_in = now + cw_ext;
               window_new    = 1'b1;
            end
         end
         bdc_pkg::PH_MULTI: begin
            if (ev == bdc_pkg::EV_PRESS) begin
               tally_in      = tally_inc;
               window_due_in = now + cw_ext;
               window_new    = 1'b1;
            end
         end
         default: begin
            if (ev == bdc_pkg::EV_PRESS) begin
               phase_in       = bdc_pkg::PH_PRESSED;
               press_start_in = now;
               long_done_in   = 1'b0;
               press_new      = 1'b1;
            end
         end
      endcase

      // A press that starts in this step has been held for zero ticks.
      hold     = press_new ? '0 : hold_old;
      win_diff = window_new ? win_diff_new : win_diff_old;

      if (phase_in == bdc_pkg::PH_PRESSED && !long_done_in &&
          hold >= TIME_WIDTH'(long_press_time)) begin
         long_done_in = 1'b1;
         tally_in     = 2'd0;
         phase_in     = bdc_pkg::PH_IDLE;
         action       = bdc_pkg::GESTURE_LONG;
      end else if (phase_in == bdc_pkg::PH_MULTI && !win_diff[TIME_WIDTH-1]) begin
         if (tally_in == bdc_pkg::TALLY_MAX) begin
            action = bdc_pkg::GESTURE_TRIPLE;
         end else if (tally_in == 2'd2) begin
            action = bdc_pkg::GESTURE_DOUBLE;
         end else begin
            action = bdc_pkg::GESTURE_SINGLE;
         end
         tally_in = 2'd0;
         phase_in = bdc_pkg::PH_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= bdc_pkg::PH_IDLE;
         press_start_ff <= '0;
         window_due_ff  <= '0;
         tally_ff       <= 2'd0;
         long_done_ff   <= 1'b0;
      end else if (step) begin
         phase_ff       <= phase_in;
         press_start_ff <= press_start_in;
         window_due_ff  <= window_due_in;
         tally_ff       <= tally_in;
         long_done_ff   <= long_done_in;
      end
   end

endmodule

// ===== design/button_debounce_click_classifier.sv =====
// Button debouncer with click classifier.
//
// Request channel (req_valid, req_ready, req_data): one transaction per poll
// of the button, carrying the current tick, an edge-seen flag and the raw
// active-low pin. Response channel (rsp_valid, rsp_ready, rsp_data): exactly
// one transaction per request, in order, with the click action, the debounced
// press or release event and the debounced level after that poll.
// Configuration channel (csr_valid, csr_ready, csr_index, csr_wdata): writes
// the debounce time, click window and long-press time; it is always ready and
// is meant to be written only while no request is outstanding.
//
// One request can be taken every cycle while the response is not stalled.
// The request is registered, the debouncer and classifier work on it
// combinationally and the result is registered. When the receiver stalls,
// the response register holds and the input register fills behind it;
// req_ready then drops until the response is taken.
// Synchronous reset empties both registers, clears the debounce and click
// state and restores the default register values (20, 400 and 700 ticks).
module button_debounce_click_classifier #(
   parameter int TIME_WIDTH = bdc_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bdc_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bdc_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bdc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bdc_pkg::CFG_WIDTH-1:0]       csr_wdata
);

   // Input register stage.
   logic             in_valid_ff, in_valid_in;
   bdc_pkg::req_type in_data_ff;

   // Output register stage.
   logic             out_valid_ff, out_valid_in;
   bdc_pkg::rsp_type out_data_ff, out_data_in;

   bdc_pkg::cfg_type cfg_ff;

   logic                    advance;
   logic [TIME_WIDTH-1:0]   now;
   bdc_pkg::deb_result_type deb;
   bdc_pkg::action_type     action;

   // The held request moves on whenever the response register is free or is
   // being emptied in this cycle.
   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;
   assign csr_ready = 1'b1;
   assign now       = in_data_ff.timestamp[TIME_WIDTH-1:0];

   bdc_debounce #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_debounce (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .now           (now),
      .edge_seen     (in_data_ff.edge_seen),
      .pressed       (~in_data_ff.pin_level),
      .debounce_time (cfg_ff.debounce_time),
      .result        (deb)
   );

   bdc_classify #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_classify (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .now             (now),
      .ev              (deb.ev),
      .click_window    (cfg_ff.click_window),
      .long_press_time (cfg_ff.long_press_time),
      .action          (action)
   );

   always_comb begin
      in_valid_in  = req_valid ? 1'b1 : (in_valid_ff & ~advance);
      out_valid_in = advance ? 1'b1 : (out_valid_ff & ~rsp_ready);

      out_data_in.action          = action;
      out_data_in.debounced_event = deb.ev;
      out_data_in.pressed_level   = deb.pressed_level;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         // req_valid only counts when req_ready is high.
         if (req_ready) begin
            in_valid_ff <= in_valid_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   // Configuration registers; indexes outside the map are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time   <= bdc_pkg::DEBOUNCE_TIME_RESET;
         cfg_ff.click_window    <= bdc_pkg::CLICK_WINDOW_RESET;
         cfg_ff.long_press_time <= bdc_pkg::LONG_PRESS_TIME_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bdc_pkg::CSR_DEBOUNCE_TIME:   cfg_ff.debounce_time   <= csr_wdata;
            bdc_pkg::CSR_CLICK_WINDOW:    cfg_ff.click_window    <= csr_wdata;
            bdc_pkg::CSR_LONG_PRESS_TIME: cfg_ff.long_press_time <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== design/bdc_checker.sv =====
module bdc_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bdc_pkg::rsp_type rsp_data
);

   // The response register is empty after reset.
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response holds its payload.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // A debounced event and the reported level agree.
   a_event_level : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.debounced_event != bdc_pkg::EV_NONE |->
         rsp_data.pressed_level == (rsp_data.debounced_event == bdc_pkg::EV_PRESS))
      else $error("debounced event disagrees with level");

   // A long press can only be reported while the button is held down.
   a_long_held : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.action == bdc_pkg::GESTURE_LONG |-> rsp_data.pressed_level)
      else $error("long press reported with button released");

endmodule

bind button_debounce_click_classifier bdc_checker u_bdc_checker (.*);
